// File: rtl/sstr_pkg.sv
package sstr_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned SEQ_W = 32;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned ENTRY_W = 72;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ENABLE  = 2'd2,
        CMD_DISABLE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic             status;
        logic             entry_valid;
        logic [31:0]      id;
        logic [31:0]      pc;
        logic [7:0]       kind;
        logic [CNT_W-1:0] count;
        logic [SEQ_W-1:0] seqno;
        logic             last;
    } result_t;

endpackage

// File: rtl/sequenced_sample_trace_ring.sv
// Trace ring of DEPTH sample entries driven by one command channel.
// The input channel carries a command with its sample fields and reader
// sequence; a transfer happens when in_valid is high and in_stall is low.
// Take sample, enable and disable give no results.
// A read gives its results on the output channel, oldest entry first, with
// last marking the final one; a read that fails or finds nothing gives one.
// A read of n entries passes the set-up state S_CALC and then issues its
// entries from S_ISSUE; the input is stalled until the last is issued.
// The first entry reaches the output through S_CALC, S_ISSUE, the memory
// read register and the output queue; a single failure or empty result goes
// through S_ONE, the in-flight result register and the output queue. The
// single read port of the ring memory sets the rate: one entry per cycle while the queue has room.
// When the receiver asserts out_stall, results wait in a two-entry output
// queue and the memory reads pause until room is free; nothing is lost.
// After reset sampling is disabled, the sequence counter is zero and every
// entry reads as zero until it is first written.
module sequenced_sample_trace_ring
    import sstr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [31:0]        sample_id,
    input  logic [31:0]        sample_pc,
    input  logic [7:0]         sample_type,
    input  logic [SEQ_W-1:0]   reader_seqno,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic               entry_valid,
    output logic [31:0]        out_id,
    output logic [31:0]        out_pc,
    output logic [7:0]         out_type,
    output logic [CNT_W-1:0]   sample_count,
    output logic [SEQ_W-1:0]   current_seqno,
    output logic               last
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               q_push;
    result_t            q_push_data;
    logic               q_pop;
    logic [1:0]         q_fill;
    result_t            head;

    assign q_pop = out_valid && !out_stall;

    sstr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sstr_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .sample_id    (sample_id),
        .sample_pc    (sample_pc),
        .sample_type  (sample_type),
        .reader_seqno (reader_seqno),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .q_fill       (q_fill),
        .q_pop        (q_pop),
        .q_push       (q_push),
        .q_push_data  (q_push_data)
    );

    sstr_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head_valid (out_valid),
        .head_data  (head),
        .fill       (q_fill)
    );

    assign status        = head.status;
    assign entry_valid   = head.entry_valid;
    assign out_id        = head.id;
    assign out_pc        = head.pc;
    assign out_type      = head.kind;
    assign sample_count  = head.count;
    assign current_seqno = head.seqno;
    assign last          = head.last;

endmodule

// File: rtl/sstr_store.sv
module sstr_store
    import sstr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    parameter int unsigned AW = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [DEPTH-1:0]   written_reg;
    logic               rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rdata_reg : '0;

endmodule

// File: rtl/sstr_outq.sv
module sstr_outq
    import sstr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    input  logic       pop,
    output logic       head_valid,
    output result_t    head_data,
    output logic [1:0] fill
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    assign head_valid = (fill_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign fill       = fill_reg;

endmodule

// File: rtl/sstr_ctrl.sv
module sstr_ctrl
    import sstr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    parameter int unsigned AW = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [31:0]        sample_id,
    input  logic [31:0]        sample_pc,
    input  logic [7:0]         sample_type,
    input  logic [SEQ_W-1:0]   reader_seqno,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [ENTRY_W-1:0] wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  logic [ENTRY_W-1:0] rd_data,
    input  logic [1:0]         q_fill,
    input  logic               q_pop,
    output logic               q_push,
    output result_t            q_push_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CALC  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_ONE   = 4'b1000
    } state_t;

    localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);
    // Remainder of 2^32 by the depth: index that would follow the last entry written before the counter wraps.
    localparam logic [AW:0] WRAP_REM = (AW+1)'((64'h1_0000_0000) % DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    state_t           state_reg, state_next;
    logic             enabled_reg, enabled_next;
    logic [SEQ_W-1:0] wseq_reg, wseq_next;
    logic [AW-1:0]    widx_reg, widx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [SEQ_W-1:0] rseq_reg, rseq_next;
    logic [AW-1:0]    ridx_reg, ridx_next;
    logic             one_fail_reg, one_fail_next;
    logic             fl_valid_reg, fl_valid_next;
    logic             fl_mem_reg, fl_mem_next;
    result_t          fl_res_reg, fl_res_next;

    logic             accept;
    logic             can_issue;
    logic [SEQ_W-1:0] diff;
    logic             diff_none;
    logic [CNT_W-1:0] n_m1;
    logic             borrow;
    logic [CNT_W-1:0] back;
    logic [AW:0]      base;
    logic [AW:0]      start_sum;
    logic [AW-1:0]    start_idx;
    logic             issue_last;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // Room for one more result once the queue and the read in flight are counted.
    assign can_issue = ({1'b0, q_fill} + {2'b00, fl_valid_reg}) < (3'd2 + {2'b00, q_pop});

    assign diff      = wseq_reg - reader_seqno;
    assign diff_none = diff[SEQ_W-1] || (diff == '0);

    assign n_m1      = n_reg - 7'd1;
    assign borrow    = (wseq_reg < {{(SEQ_W-CNT_W){1'b0}}, n_m1});
    assign back      = borrow ? (n_m1 - wseq_reg[CNT_W-1:0]) : n_m1;
    assign base      = borrow ? WRAP_REM : {1'b0, widx_reg};
    assign start_sum = base + DEPTH_W - (AW+1)'(back);
    assign start_idx = (start_sum >= DEPTH_W) ? AW'(start_sum - DEPTH_W) : AW'(start_sum);

    assign issue_last = ((k_reg + 7'd1) == n_reg);

    assign wr_data = {sample_id, sample_pc, sample_type};
    assign rd_addr = ridx_reg;

    always_comb
    begin
        state_next    = state_reg;
        enabled_next  = enabled_reg;
        wseq_next     = wseq_reg;
        widx_next     = widx_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        rseq_next     = rseq_reg;
        ridx_next     = ridx_reg;
        one_fail_next = one_fail_reg;
        fl_valid_next = 1'b0;
        fl_mem_next   = fl_mem_reg;
        fl_res_next   = fl_res_reg;
        wr_en         = 1'b0;
        wr_addr       = widx_reg;
        rd_en         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(command))
                        CMD_SAMPLE:
                        begin
                            if (enabled_reg)
                            begin
                                wseq_next = wseq_reg + 32'd1;
                                if ((wseq_reg == '1) || (widx_reg == LAST_IDX))
                                begin
                                    widx_next = '0;
                                end
                                else
                                begin
                                    widx_next = widx_reg + AW'(1);
                                end
                                wr_en   = 1'b1;
                                wr_addr = widx_next;
                            end
                        end
                        CMD_ENABLE:
                        begin
                            if (!enabled_reg)
                            begin
                                enabled_next = 1'b1;
                                wseq_next    = '0;
                                widx_next    = '0;
                            end
                        end
                        CMD_DISABLE:
                        begin
                            enabled_next = 1'b0;
                            wseq_next    = '0;
                            widx_next    = '0;
                        end
                        CMD_READ:
                        begin
                            if (!enabled_reg)
                            begin
                                one_fail_next = 1'b1;
                                state_next    = S_ONE;
                            end
                            else if (diff_none)
                            begin
                                one_fail_next = 1'b0;
                                state_next    = S_ONE;
                            end
                            else
                            begin
                                if (diff > SEQ_W'(DEPTH))
                                begin
                                    n_next = CNT_W'(DEPTH);
                                end
                                else
                                begin
                                    n_next = diff[CNT_W-1:0];
                                end
                                state_next = S_CALC;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                ridx_next  = start_idx;
                rseq_next  = wseq_reg - {{(SEQ_W-CNT_W){1'b0}}, n_m1};
                k_next     = '0;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (can_issue)
                begin
                    rd_en         = 1'b1;
                    fl_valid_next = 1'b1;
                    fl_mem_next   = 1'b1;
                    fl_res_next   = '{status: 1'b0, entry_valid: 1'b1, id: '0, pc: '0,
                                      kind: '0, count: n_reg, seqno: wseq_reg,
                                      last: issue_last};
                    k_next        = k_reg + 7'd1;
                    rseq_next     = rseq_reg + 32'd1;
                    if ((rseq_reg == '1) || (ridx_reg == LAST_IDX))
                    begin
                        ridx_next = '0;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + AW'(1);
                    end
                    if (issue_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ONE:
            begin
                if (can_issue)
                begin
                    fl_valid_next = 1'b1;
                    fl_mem_next   = 1'b0;
                    fl_res_next   = '{status: one_fail_reg, entry_valid: 1'b0, id: '0,
                                      pc: '0, kind: '0, count: '0,
                                      seqno: one_fail_reg ? '0 : wseq_reg, last: 1'b1};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            enabled_reg  <= 1'b0;
            wseq_reg     <= '0;
            widx_reg     <= '0;
            fl_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            enabled_reg  <= enabled_next;
            wseq_reg     <= wseq_next;
            widx_reg     <= widx_next;
            fl_valid_reg <= fl_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        rseq_reg     <= rseq_next;
        ridx_reg     <= ridx_next;
        one_fail_reg <= one_fail_next;
        fl_mem_reg   <= fl_mem_next;
        fl_res_reg   <= fl_res_next;
    end

    always_comb
    begin
        q_push_data = fl_res_reg;
        if (fl_mem_reg)
        begin
            q_push_data.id   = rd_data[71:40];
            q_push_data.pc   = rd_data[39:8];
            q_push_data.kind = rd_data[7:0];
        end
    end

    assign q_push = fl_valid_reg;

endmodule
